// ===== design/plist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

  // request command codes
  localparam logic [3:0] CMD_PUSH_END   = 4'd0;
  localparam logic [3:0] CMD_PUSH_FRONT = 4'd1;
  localparam logic [3:0] CMD_INSERT     = 4'd2;
  localparam logic [3:0] CMD_EXTRACT    = 4'd3;
  localparam logic [3:0] CMD_EXT_FRONT  = 4'd4;
  localparam logic [3:0] CMD_EXT_END    = 4'd5;
  localparam logic [3:0] CMD_READ       = 4'd6;
  localparam logic [3:0] CMD_WRITE      = 4'd7;
  localparam logic [3:0] CMD_SWAP       = 4'd8;

  // response status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAP,
    ST_APPLY
  } plist_state_t;

  // what the row of cells does
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_LOAD,
    ACT_SWAP
  } plist_act_t;

  typedef struct packed {
    plist_act_t act;
    logic       at;     // cell is the selected position
    logic       after;  // cell lies beyond the selected position
    logic       at2;    // cell is the second swap position
  } plist_cell_ctl_t;

endpackage

// ===== design/plist_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_cell
// One list entry: holds, loads, or takes a neighbour's word.
// ----------------------------------------------------------------------------
module plist_cell import plist_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  plist_cell_ctl_t      ctl,
  input  logic [WIDTH-1:0]     from_left,
  input  logic [WIDTH-1:0]     from_right,
  input  logic [WIDTH-1:0]     word_a,
  input  logic [WIDTH-1:0]     word_b,
  output logic [WIDTH-1:0]     q
);

  logic [WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctl.act)
      ACT_HOLD: q_next = q;
      ACT_INSERT: begin
        if (ctl.at) begin
          q_next = word_a;
        end else if (ctl.after) begin
          q_next = from_left;
        end
      end
      ACT_REMOVE: begin
        if (ctl.at || ctl.after) begin
          q_next = from_right;
        end
      end
      ACT_LOAD: begin
        if (ctl.at) begin
          q_next = word_a;
        end
      end
      ACT_SWAP: begin
        if (ctl.at) begin
          q_next = word_a;
        end else if (ctl.at2) begin
          q_next = word_b;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== design/plist_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_chain
// Row of list cells with neighbour links and a single read tap.
// ----------------------------------------------------------------------------
module plist_chain import plist_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  plist_act_t        act,
  input  logic [AW-1:0]     sel,
  input  logic [AW-1:0]     sel2,
  input  logic [WIDTH-1:0]  word_a,
  input  logic [WIDTH-1:0]  word_b,
  input  logic [AW-1:0]     rd_sel,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    plist_cell_ctl_t  ctl;
    logic [WIDTH-1:0] left_w;
    logic [WIDTH-1:0] right_w;

    assign ctl.act   = act;
    assign ctl.at    = (sel == AW'(i));
    assign ctl.after = (sel < AW'(i));
    assign ctl.at2   = (sel2 == AW'(i));

    // the ends of the row feed back their own word
    if (i == 0) begin : g_first
      assign left_w = cell_q[i];
    end else begin : g_left
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_right
      assign right_w = cell_q[i+1];
    end

    plist_cell #(.WIDTH(WIDTH)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_left  (left_w),
      .from_right (right_w),
      .word_a     (word_a),
      .word_b     (word_b),
      .q          (cell_q[i])
    );
  end

  assign rd_data = cell_q[rd_sel];

endmodule

// ===== design/positional_list_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// req     | req_valid/req_stall  | cmd, position, second_position, value
// rsp     | rsp_valid/rsp_stall  | data_out, entries_now, status
// cfg     | cfg_valid/cfg_ready  | cfg_data (list limit)
//
// Each request passes through three steps: accept, tap read of one cell, apply.
// The apply cycle waits while the previous response is still stalled.
// Insert and extract shift every later cell in the apply cycle itself.
// Reset clears the entry count and sets the limit to 64; cells are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_core import plist_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [3:0]         cmd,
  input  logic signed [7:0]  position,
  input  logic [5:0]         second_position,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] data_out,
  output logic [6:0]         entries_now,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  plist_state_t state, state_next;

  logic [6:0]        limit;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  logic [3:0]        cmd_q;
  logic [7:0]        pos_q;
  logic [5:0]        pos2_q;
  logic [31:0]       value_q;

  plist_act_t        act_q, act_d;
  logic [AW-1:0]     sel_q, sel_d;
  logic [AW-1:0]     sel2_q;
  logic [WIDTH-1:0]  word_q, word_d;
  logic [1:0]        status_q, status_d;
  logic              use_tap_q, use_tap_d;
  logic [WIDTH-1:0]  tap_q;

  logic [CMPW-1:0]   cnt_x, pos_x, pos2_x, lim_x, cap_x, cnt_m1, cnt_next_x;
  logic              pos_neg, full, empty, pos_lt_cnt;
  logic [AW-1:0]     tap_idx;
  logic signed [63:0] val64;

  logic              accept, apply_go, rsp_free;
  logic [AW-1:0]     rd_sel;
  logic [WIDTH-1:0]  rd_data;
  plist_act_t        chain_act;
  logic [WIDTH-1:0]  word_a;
  logic signed [WIDTH-1:0] tap_s;
  logic signed [63:0] tap64;

  assign accept   = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;

  // comparisons at a common width
  assign cnt_x   = CMPW'(count);
  assign pos_x   = CMPW'(pos_q[6:0]);
  assign pos2_x  = CMPW'(pos2_q);
  assign lim_x   = CMPW'(limit);
  assign cap_x   = (lim_x > CMPW'(DEPTH)) ? CMPW'(DEPTH) : lim_x;
  assign cnt_m1  = cnt_x - CMPW'(1);
  assign pos_neg = pos_q[7];
  assign full    = (cnt_x >= cap_x);
  assign empty   = (count == '0);
  assign pos_lt_cnt = !pos_neg && (pos_x < cnt_x);
  assign val64   = 64'(signed'(value_q));

  // entry to tap in the read cycle
  always_comb begin
    tap_idx = pos_x[AW-1:0];
    unique case (cmd_q)
      CMD_EXT_FRONT: tap_idx = '0;
      CMD_EXT_END:   tap_idx = cnt_m1[AW-1:0];
      default:       tap_idx = pos_x[AW-1:0];
    endcase
  end

  // decode the request against the current count and limit
  always_comb begin
    act_d     = ACT_HOLD;
    sel_d     = pos_x[AW-1:0];
    word_d    = val64[WIDTH-1:0];
    status_d  = STAT_OK;
    use_tap_d = 1'b0;
    unique case (cmd_q)
      CMD_PUSH_END, CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          act_d = ACT_INSERT;
          sel_d = (cmd_q == CMD_PUSH_END) ? cnt_x[AW-1:0] : '0;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else if (pos_neg || (pos_x > cnt_x)) begin
          status_d = STAT_RANGE;
        end else begin
          act_d = ACT_INSERT;
        end
      end
      CMD_EXTRACT: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else if (!pos_lt_cnt) begin
          status_d = STAT_RANGE;
        end else begin
          act_d     = ACT_REMOVE;
          use_tap_d = 1'b1;
        end
      end
      CMD_EXT_FRONT, CMD_EXT_END: begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          act_d     = ACT_REMOVE;
          sel_d     = tap_idx;
          use_tap_d = 1'b1;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (pos_lt_cnt) begin
          if (cmd_q == CMD_READ) begin
            use_tap_d = 1'b1;
          end else begin
            act_d = ACT_LOAD;
          end
        end else if (full) begin
          status_d = STAT_FULL;
        end else begin
          // pushing a zero then writing it is a push of the written word
          act_d  = ACT_INSERT;
          sel_d  = pos_neg ? '0 : cnt_x[AW-1:0];
          if (cmd_q == CMD_READ) begin
            word_d = '0;
          end
        end
      end
      CMD_SWAP: begin
        if (!pos_lt_cnt || (pos2_x >= cnt_x)) begin
          status_d = STAT_RANGE;
        end else begin
          act_d = ACT_SWAP;
        end
      end
      default: act_d = ACT_HOLD;
    endcase
  end

  always_comb begin
    cnt_next_x = cnt_x;
    unique case (act_q)
      ACT_INSERT: cnt_next_x = cnt_x + CMPW'(1);
      ACT_REMOVE: cnt_next_x = cnt_m1;
      default:    cnt_next_x = cnt_x;
    endcase
  end
  assign count_next = cnt_next_x[CW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_TAP;
      ST_TAP:   state_next = ST_APPLY;
      ST_APPLY: if (rsp_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_stall = 1'b1;
    apply_go  = 1'b0;
    rd_sel    = tap_idx;
    unique case (state)
      ST_IDLE:  req_stall = 1'b0;
      ST_TAP:   rd_sel = tap_idx;
      ST_APPLY: begin
        apply_go = rsp_free;
        rd_sel   = sel2_q;
      end
      default:  req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      limit     <= LIMIT_RESET;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (apply_go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign tap_s = signed'(tap_q);
  assign tap64 = 64'(tap_s);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      pos_q   <= position;
      pos2_q  <= second_position;
      value_q <= value;
    end
    if (state == ST_TAP) begin
      act_q     <= act_d;
      sel_q     <= sel_d;
      sel2_q    <= pos2_x[AW-1:0];
      word_q    <= word_d;
      status_q  <= status_d;
      use_tap_q <= use_tap_d;
      tap_q     <= rd_data;
    end
    if (apply_go) begin
      data_out    <= use_tap_q ? tap64[31:0] : '0;
      entries_now <= cnt_next_x[6:0];
      status      <= status_q;
    end
  end

  // swap: first position takes the second's word straight off the tap
  assign chain_act = apply_go ? act_q : ACT_HOLD;
  assign word_a    = (act_q == ACT_SWAP) ? rd_data : word_q;

  plist_chain #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_chain (
    .clk     (clk),
    .act     (chain_act),
    .sel     (sel_q),
    .sel2    (sel2_q),
    .word_a  (word_a),
    .word_b  (tap_q),
    .rd_sel  (rd_sel),
    .rd_data (rd_data)
  );

endmodule

// ===== design/plist_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plist_checker
// Port-level checks for the positional list engine.
// ----------------------------------------------------------------------------
module plist_checker import plist_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] data_out,
  input logic [6:0]         entries_now,
  input logic [1:0]         status
);

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted back to back");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != STAT_OK) |-> data_out == '0)
    else $error("failed response carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STAT_EMPTY) |-> entries_now == '0)
    else $error("empty status with entries present");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(data_out) && $stable(status)
      && $stable(entries_now))
    else $error("stalled response changed");

endmodule

bind positional_list_engine_core plist_checker u_plist_checker (.*);
